// ===== hdl/tqps_pkg.sv =====
// package for the two queue priority server
// types, codes and sizes shared by the rtl; no dependencies
package tqps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        K_PREQ = 3'd0, K_NREQ = 3'd1, K_TICK = 3'd2,
        K_PCAN = 3'd3, K_NCAN = 3'd4, K_CLR = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_ACCEPTED = 3'd0, S_REFUSED = 3'd1, S_PSERVED = 3'd2, S_NSERVED = 3'd3,
        S_IDLE = 3'd4, S_REMOVED = 3'd5, S_NOTFOUND = 3'd6, S_CLEARED = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE, ST_HEAD, ST_SCAN, ST_SHIFT, ST_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] flight;
        logic [15:0] time_req;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] served_flight;
        logic [15:0] wait_time;
        logic [4:0]  priority_length;
        logic [4:0]  normal_length;
        logic [31:0] priority_requests;
        logic [31:0] normal_requests;
        logic [31:0] priority_refused;
        logic [31:0] normal_refused;
        logic [31:0] priority_served;
        logic [31:0] normal_served;
        logic [31:0] idle_ticks;
    } t_out;

endpackage

// ===== hdl/two_queue_priority_server.sv =====
// two queue priority server top level
// uses tqps_pkg; both queues live in synchronous-read memories
//
//  channel  signals                             carries
//  in       i_in_valid o_in_stall i_in          item transfer into the block
//  out      o_out_valid i_out_stall o_out       result transfer out
//  cfg      i_cfg_valid o_cfg_ready i_cfg_data  limit register write
//
// requests, clear and an idle tick pass ST_HEAD and ST_OUT; a served tick adds
// ST_SHIFT (tail shift), a cancel on a non-empty queue ST_SCAN and, on a match,
// ST_SHIFT; scan reads one entry a cycle to the match, the tail then moves up one
// entry a cycle. the input stays stalled until the result is loaded, back in idle.
// reset clears counts, counters and control; queue memories are not cleared.
// the result register holds under o_out stall; a new item is taken only once
// the result register is empty or being transferred.
module two_queue_priority_server import tqps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    logic [31:0] r_pmem [QUEUE_DEPTH];
    logic [31:0] r_nmem [QUEUE_DEPTH];
    logic [31:0] r_prd, r_nrd;

    t_state      r_state, n_state;
    t_in         r_item, n_item;
    logic [CW-1:0] r_pcnt, n_pcnt, r_ncnt, n_ncnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [31:0] r_ctr [7];
    logic [31:0] n_ctr [7];
    logic [4:0]  r_limit;
    logic [2:0]  r_status, n_status;
    logic [15:0] r_sf, n_sf, r_wt, n_wt;
    logic        r_ov, n_ov;
    t_out        r_out, n_out;

    logic [AW-1:0] rd_addr;
    logic          we_p, we_n;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          take;
    logic [31:0]   rd;
    logic [CW-1:0] cnt, lim;
    logic          isp;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out = r_out;
    assign o_in_stall = (r_state != ST_IDLE) || (r_ov && i_out_stall);
    assign take = i_in_valid && !o_in_stall;

    assign isp = (r_item.kind == K_PREQ) || (r_item.kind == K_PCAN) ||
                 (r_item.kind == K_TICK && r_pcnt != '0);
    assign cnt = isp ? r_pcnt : r_ncnt;
    assign rd = isp ? r_prd : r_nrd;
    assign lim = (r_limit > 5'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(r_limit);

    always_ff @(posedge i_clk) begin
        if (we_p) r_pmem[wr_addr] <= wr_data;
        if (we_n) r_nmem[wr_addr] <= wr_data;
        r_prd <= r_pmem[rd_addr];
        r_nrd <= r_nmem[rd_addr];
    end

    function automatic logic [31:0] sat(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    always_comb begin
        n_state = r_state;
        n_item = r_item;
        n_pcnt = r_pcnt;
        n_ncnt = r_ncnt;
        n_idx = r_idx;
        n_ctr = r_ctr;
        n_status = r_status;
        n_sf = r_sf;
        n_wt = r_wt;
        n_ov = r_ov && i_out_stall;
        n_out = r_out;
        rd_addr = r_idx[AW-1:0];
        we_p = 1'b0;
        we_n = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = rd;
        unique case (r_state)
            ST_IDLE: begin
                if (take && i_in.kind <= K_CLR) begin
                    n_item = i_in;
                    n_idx = '0;
                    n_sf = '0;
                    n_wt = '0;
                    rd_addr = '0;
                    n_state = ST_HEAD;
                end
            end
            ST_HEAD: begin
                n_state = ST_OUT;
                unique case (r_item.kind)
                    K_PREQ, K_NREQ: begin
                        n_ctr[isp ? 0 : 1] = sat(r_ctr[isp ? 0 : 1]);
                        if (cnt < lim) begin
                            wr_addr = cnt[AW-1:0];
                            wr_data = {r_item.flight, r_item.time_req};
                            we_p = isp;
                            we_n = !isp;
                            if (isp) n_pcnt = r_pcnt + 1'b1;
                            else n_ncnt = r_ncnt + 1'b1;
                            n_status = S_ACCEPTED;
                        end else begin
                            n_ctr[isp ? 2 : 3] = sat(r_ctr[isp ? 2 : 3]);
                            n_status = S_REFUSED;
                        end
                    end
                    K_TICK: begin
                        if (cnt == '0) begin
                            n_ctr[6] = sat(r_ctr[6]);
                            n_status = S_IDLE;
                        end else begin
                            n_ctr[isp ? 4 : 5] = sat(r_ctr[isp ? 4 : 5]);
                            n_status = isp ? S_PSERVED : S_NSERVED;
                            n_sf = rd[31:16];
                            n_wt = (r_item.time_req >= rd[15:0]) ?
                                   r_item.time_req - rd[15:0] : 16'd0;
                            n_idx = '0;
                            rd_addr = AW'(1);
                            n_state = ST_SHIFT;
                        end
                    end
                    K_PCAN, K_NCAN: begin
                        n_status = S_NOTFOUND;
                        if (cnt != '0) n_state = ST_SCAN;
                    end
                    default: begin
                        n_ctr = '{default: '0};
                        n_status = S_CLEARED;
                    end
                endcase
            end
            ST_SCAN: begin
                // rd holds entry r_idx
                if (rd[31:16] == r_item.flight) begin
                    n_status = S_REMOVED;
                    rd_addr = AW'(r_idx + 1'b1);
                    n_state = ST_SHIFT;
                end else if (r_idx + 1'b1 >= cnt) begin
                    n_state = ST_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    rd_addr = AW'(r_idx + 1'b1);
                    n_state = ST_SCAN;
                end
            end
            ST_SHIFT: begin
                // rd holds entry r_idx+1 once addressed the cycle before
                if (r_idx + 1'b1 >= cnt) begin
                    if (isp) n_pcnt = r_pcnt - 1'b1;
                    else n_ncnt = r_ncnt - 1'b1;
                    n_state = ST_OUT;
                end else begin
                    wr_addr = r_idx[AW-1:0];
                    we_p = isp;
                    we_n = !isp;
                    n_idx = r_idx + 1'b1;
                    rd_addr = AW'(r_idx + 2'd2);
                end
            end
            default: begin
                n_ov = 1'b1;
                n_out = '{status: r_status, served_flight: r_sf, wait_time: r_wt,
                          priority_length: 5'(r_pcnt), normal_length: 5'(r_ncnt),
                          priority_requests: r_ctr[0], normal_requests: r_ctr[1],
                          priority_refused: r_ctr[2], normal_refused: r_ctr[3],
                          priority_served: r_ctr[4], normal_served: r_ctr[5],
                          idle_ticks: r_ctr[6]};
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pcnt <= '0;
            r_ncnt <= '0;
            r_ctr <= '{default: '0};
            r_limit <= 5'd16;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pcnt <= n_pcnt;
            r_ncnt <= n_ncnt;
            r_ctr <= n_ctr;
            r_ov <= n_ov;
            if (i_cfg_valid) r_limit <= i_cfg_data;
        end
        r_item <= n_item;
        r_idx <= n_idx;
        r_status <= n_status;
        r_sf <= n_sf;
        r_wt <= n_wt;
        r_out <= n_out;
    end
endmodule
